>>> sv/bplru_pkg.sv
// Shared types and codes for the buffer pool LRU directory.
// Holds the input and result word layouts, the directory entry layout and command/status codes.
// No dependencies.
package bplru_pkg;

    localparam logic [1:0] CMD_FETCH      = 2'd0;
    localparam logic [1:0] CMD_FETCH_EXCL = 2'd1;
    localparam logic [1:0] CMD_MARK       = 2'd2;
    localparam logic [1:0] CMD_INVAL      = 2'd3;

    localparam logic [2:0] ST_HIT       = 3'd0;
    localparam logic [2:0] ST_FREE      = 3'd1;
    localparam logic [2:0] ST_CLEAN     = 3'd2;
    localparam logic [2:0] ST_DIRTY     = 3'd3;
    localparam logic [2:0] ST_NO_VICTIM = 3'd4;

    localparam logic [15:0] AGE_MAX = 16'hFFFF;

    typedef struct packed {
        logic [1:0]  cmd;
        logic [7:0]  file_id;
        logic [15:0] block_offset;
        logic [5:0]  slot;
    } t_in;

    typedef struct packed {
        logic [5:0]  slot_out;
        logic [2:0]  status;
        logic [7:0]  evict_file;
        logic [15:0] evict_offset;
    } t_out;

    typedef struct packed {
        logic        valid;
        logic        dirty;
        logic [7:0]  file_id;
        logic [15:0] blk;
        logic [15:0] age;
    } t_entry;

endpackage

>>> sv/buffer_pool_lru_directory.sv
// Buffer pool LRU directory over SLOTS directory entries; depends on bplru_pkg and bplru_ram.
// Per word: a fetch sweeps every entry, then decides in S_FEND; an invalidate sweeps; a mark
// reads its slot in S_MWAIT and sweeps only if it is valid, or on a slot not below SLOTS goes
// straight to S_DONE; a stalled output holds the next result in S_DONE. One word in flight;
// the next is taken in the cycle after the result loads; each sweep reads one entry a cycle.
// Reset: a clearing pass zeroes every entry; no word is taken until it ends.
module buffer_pool_lru_directory #(
    parameter int SLOTS = 64
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    output logic             o_stall,
    input  bplru_pkg::t_in   i_data,
    output logic             o_valid,
    input  logic             i_stall,
    output bplru_pkg::t_out  o_data
);

    localparam int IW = $clog2(SLOTS);
    localparam int EW = $bits(bplru_pkg::t_entry);
    localparam logic [IW:0] SWEEP_END = (IW+1)'(SLOTS);

    typedef enum logic [5:0] {
        S_CLEAR = 6'b000001,
        S_IDLE  = 6'b000010,
        S_MWAIT = 6'b000100,
        S_SWEEP = 6'b001000,
        S_FEND  = 6'b010000,
        S_DONE  = 6'b100000
    } t_state;

    t_state            r_state, n_state;
    bplru_pkg::t_in    r_in, n_in;
    logic [IW:0]       r_rd_idx, n_rd_idx;
    logic              r_pend, n_pend;
    logic [IW-1:0]     r_pidx, n_pidx;
    logic              r_hit_found, n_hit_found;
    logic [IW-1:0]     r_hit_idx, n_hit_idx;
    logic              r_free_found, n_free_found;
    logic [IW-1:0]     r_free_idx, n_free_idx;
    logic              r_vic_found, n_vic_found;
    logic [IW-1:0]     r_vic_idx, n_vic_idx;
    bplru_pkg::t_entry r_vic, n_vic;
    bplru_pkg::t_out   r_res, n_res;
    logic              r_out_valid, n_out_valid;
    bplru_pkg::t_out   r_out, n_out;

    logic              ram_we;
    logic [IW-1:0]     ram_waddr;
    bplru_pkg::t_entry ram_wdata;
    logic [IW-1:0]     ram_raddr;
    logic [EW-1:0]     ram_rdata;
    bplru_pkg::t_entry rd_entry;
    logic              sweep_issue;
    logic              slot_ok;
    logic              excl;

    bplru_ram #(
        .WIDTH(EW),
        .DEPTH(SLOTS)
    ) u_ram (
        .i_clk  (i_clk),
        .i_we   (ram_we),
        .i_waddr(ram_waddr),
        .i_wdata(EW'(ram_wdata)),
        .i_raddr(ram_raddr),
        .o_rdata(ram_rdata)
    );

    assign rd_entry    = bplru_pkg::t_entry'(ram_rdata);
    assign sweep_issue = (r_rd_idx != SWEEP_END);
    assign slot_ok     = (32'(i_data.slot) < SLOTS);
    assign excl        = (r_in.cmd == bplru_pkg::CMD_FETCH_EXCL);

    always_comb begin
        n_state      = r_state;
        n_in         = r_in;
        n_rd_idx     = r_rd_idx;
        n_pend       = r_pend;
        n_pidx       = r_pidx;
        n_hit_found  = r_hit_found;
        n_hit_idx    = r_hit_idx;
        n_free_found = r_free_found;
        n_free_idx   = r_free_idx;
        n_vic_found  = r_vic_found;
        n_vic_idx    = r_vic_idx;
        n_vic        = r_vic;
        n_res        = r_res;
        n_out_valid  = r_out_valid;
        n_out        = r_out;
        ram_we       = 1'b0;
        ram_waddr    = r_pidx;
        ram_wdata    = rd_entry;
        ram_raddr    = r_rd_idx[IW-1:0];

        if (r_out_valid && !i_stall) begin
            n_out_valid = 1'b0;
        end

        // sweep engine: read one entry a cycle, process it when it returns
        if (r_state == S_CLEAR || r_state == S_SWEEP) begin
            n_pend = sweep_issue;
            n_pidx = r_rd_idx[IW-1:0];
            if (sweep_issue) begin
                n_rd_idx = r_rd_idx + 1'b1;
            end
        end

        case (r_state)
            S_CLEAR: begin
                if (r_pend) begin
                    ram_we    = 1'b1;
                    ram_wdata = '0;
                end
                if (!sweep_issue && !r_pend) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                ram_raddr = IW'(i_data.slot);
                if (i_valid) begin
                    n_in         = i_data;
                    n_res        = '0;
                    n_hit_found  = 1'b0;
                    n_free_found = 1'b0;
                    n_vic_found  = 1'b0;
                    if (i_data.cmd == bplru_pkg::CMD_MARK) begin
                        n_state = slot_ok ? S_MWAIT : S_DONE;
                    end else begin
                        n_rd_idx = '0;
                        n_pend   = 1'b0;
                        n_state  = S_SWEEP;
                    end
                end
            end
            S_MWAIT: begin
                // age the pool only when the marked slot holds a block
                if (rd_entry.valid) begin
                    n_rd_idx = '0;
                    n_pend   = 1'b0;
                    n_state  = S_SWEEP;
                end else begin
                    n_state = S_DONE;
                end
            end
            S_SWEEP: begin
                if (r_pend) begin
                    if (r_in.cmd inside {bplru_pkg::CMD_FETCH, bplru_pkg::CMD_FETCH_EXCL}) begin
                        if (!r_hit_found && rd_entry.valid && rd_entry.file_id == r_in.file_id
                                && rd_entry.blk == r_in.block_offset) begin
                            n_hit_found = 1'b1;
                            n_hit_idx   = r_pidx;
                        end
                        if (!r_free_found && !rd_entry.valid) begin
                            n_free_found = 1'b1;
                            n_free_idx   = r_pidx;
                        end
                        // strict compare keeps the lowest index on equal ages
                        if (!(excl && rd_entry.file_id == r_in.file_id)
                                && (!r_vic_found || rd_entry.age > r_vic.age)) begin
                            n_vic_found = 1'b1;
                            n_vic_idx   = r_pidx;
                            n_vic       = rd_entry;
                        end
                    end else if (r_in.cmd == bplru_pkg::CMD_MARK) begin
                        ram_we = 1'b1;
                        if (r_pidx == IW'(r_in.slot)) begin
                            ram_wdata.dirty = 1'b1;
                            ram_wdata.age   = '0;
                        end else if (rd_entry.age != bplru_pkg::AGE_MAX) begin
                            ram_wdata.age = rd_entry.age + 16'd1;
                        end
                    end else begin
                        if (rd_entry.valid && rd_entry.file_id == r_in.file_id) begin
                            ram_we          = 1'b1;
                            ram_wdata.valid = 1'b0;
                            ram_wdata.dirty = 1'b0;
                        end
                    end
                end
                if (!sweep_issue && !r_pend) begin
                    if (r_in.cmd inside {bplru_pkg::CMD_FETCH, bplru_pkg::CMD_FETCH_EXCL}) begin
                        n_state = S_FEND;
                    end else begin
                        n_state = S_DONE;
                    end
                end
            end
            S_FEND: begin
                ram_wdata.valid   = 1'b1;
                ram_wdata.dirty   = 1'b0;
                ram_wdata.file_id = r_in.file_id;
                ram_wdata.blk     = r_in.block_offset;
                ram_wdata.age     = '0;
                if (r_hit_found) begin
                    n_res.slot_out = 6'(r_hit_idx);
                    n_res.status   = bplru_pkg::ST_HIT;
                end else if (r_free_found) begin
                    ram_we         = 1'b1;
                    ram_waddr      = r_free_idx;
                    n_res.slot_out = 6'(r_free_idx);
                    n_res.status   = bplru_pkg::ST_FREE;
                end else if (r_vic_found) begin
                    ram_we         = 1'b1;
                    ram_waddr      = r_vic_idx;
                    n_res.slot_out = 6'(r_vic_idx);
                    if (r_vic.dirty) begin
                        n_res.status       = bplru_pkg::ST_DIRTY;
                        n_res.evict_file   = r_vic.file_id;
                        n_res.evict_offset = r_vic.blk;
                    end else begin
                        n_res.status = bplru_pkg::ST_CLEAN;
                    end
                end else begin
                    n_res.status = bplru_pkg::ST_NO_VICTIM;
                end
                n_state = S_DONE;
            end
            S_DONE: begin
                // load the result word once the output register frees up
                if (!r_out_valid || !i_stall) begin
                    n_out       = r_res;
                    n_out_valid = 1'b1;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_CLEAR;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_rd_idx    <= '0;
            r_pend      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_rd_idx    <= n_rd_idx;
            r_pend      <= n_pend;
            r_out_valid <= n_out_valid;
        end
        r_in         <= n_in;
        r_pidx       <= n_pidx;
        r_hit_found  <= n_hit_found;
        r_hit_idx    <= n_hit_idx;
        r_free_found <= n_free_found;
        r_free_idx   <= n_free_idx;
        r_vic_found  <= n_vic_found;
        r_vic_idx    <= n_vic_idx;
        r_vic        <= n_vic;
        r_res        <= n_res;
        r_out        <= n_out;
    end

    assign o_stall = (r_state != S_IDLE);
    assign o_valid = r_out_valid;
    assign o_data  = r_out;

    a_idle_sweep_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_IDLE |-> r_rd_idx == SWEEP_END && !r_pend)
        else $error("idle with a sweep still running");

    a_fend_no_pending: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_FEND |-> !r_pend && r_rd_idx == SWEEP_END)
        else $error("fetch decided before scan finished");

    a_hit_no_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_FEND && r_hit_found |-> !ram_we)
        else $error("directory written on a hit");

    a_done_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_DONE && r_out_valid && i_stall |=> r_state == S_DONE && $stable(r_out))
        else $error("result overwrote a pending output word");

    a_write_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ram_we |-> 32'(ram_waddr) < SLOTS)
        else $error("write beyond last slot");

endmodule

>>> sv/bplru_ram.sv
// Generic simple dual-port RAM: one write port, one read port with registered read data.
// No dependencies.
module bplru_ram #(
    parameter int WIDTH = 42,
    parameter int DEPTH = 64,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule
